>>> src/aes128_block_cipher_assert.svh
// assertion macros for the aes-128 block cipher
// used by the top level, no other dependencies
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// condition a implies condition b in the same cycle
`define AES_ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// condition a implies that expression x is unchanged in the next cycle
`define AES_ASSERT_HOLDS(lbl, clk, rst_n, a, x) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> $stable(x)) \
    else $error("assertion failed");

`endif

>>> src/aes_pkg.sv
// shared types, tables and round functions of the aes-128 cipher
// no dependencies
package aes_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumKeys   = NumRounds + 1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_DECRYPT  = 2'd2;

  localparam logic [7:0] RCON [NumKeys] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 of the state sits at the top of the word, byte i at bits 127-8*i
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return o;
  endfunction

  // byte c*4+r is column c, row r; row r rotates by r
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [1:0]   src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 2'(c - r) : 2'(c + r);
        o[127-8*(c*4+r) -: 8] = s[127-8*(int'(src)*4+r) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   a  [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = s[127-8*(c*4+k) -: 8];
        x2[k]  = xtime(a[k]);
        x4[k]  = xtime(x2[k]);
        x8[k]  = xtime(x4[k]);
        m9[k]  = x8[k] ^ a[k];
        m11[k] = x8[k] ^ x2[k] ^ a[k];
        m13[k] = x8[k] ^ x4[k] ^ a[k];
        m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[127-8*(c*4+r) -: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
        end else begin
          o[127-8*(c*4+r) -: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4]
                                  ^ a[(r+3)%4];
        end
      end
    end
    return o;
  endfunction

endpackage

>>> src/aes_round.sv
// one pipeline stage holding one cipher round, forward or inverse
// depends on aes_pkg
module aes_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           decrypt_i,
  input  logic           last_i,
  input  logic           valid_i,
  input  logic [127:0]   state_i,
  input  logic [127:0]   key_i,
  output logic           valid_o,
  output logic [127:0]   state_o
);
  import aes_pkg::*;

  logic [127:0] enc_sh, enc_mx, dec_sb, dec_ak, state_d, state_q;
  logic         valid_q;

  // forward: sub, shift, mix, key; inverse: shift, sub, key, mix; the last round skips the mix
  always_comb begin
    enc_sh = shift_rows(sub_bytes(state_i, 1'b0), 1'b0);
    enc_mx = last_i ? enc_sh : mix_columns(enc_sh, 1'b0);
    dec_sb = sub_bytes(shift_rows(state_i, 1'b1), 1'b1);
    dec_ak = dec_sb ^ key_i;
    state_d = decrypt_i ? (last_i ? dec_ak : mix_columns(dec_ak, 1'b1))
                        : (enc_mx ^ key_i);
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule

>>> src/aes_key_expand.sv
// round key expansion, one round key per cycle, and the round key registers
// depends on aes_pkg
module aes_key_expand (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [127:0]                               key_i,
  output logic                                       busy_o,
  output logic [aes_pkg::NumKeys-1:0][127:0]         round_keys_o
);
  import aes_pkg::*;

  logic [NumKeys-1:0][127:0] rk_q;
  logic [127:0]              cur_q, next_key;
  logic [3:0]                cnt_q;
  logic                      busy_q;
  logic [31:0]               w3, tmp;

  // next round key from the previous one
  always_comb begin
    w3  = cur_q[31:0];
    tmp = {SBOX[w3[23:16]] ^ RCON[cnt_q], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    next_key[127:96] = cur_q[127:96] ^ tmp;
    next_key[95:64]  = cur_q[95:64] ^ next_key[127:96];
    next_key[63:32]  = cur_q[63:32] ^ next_key[95:64];
    next_key[31:0]   = cur_q[31:0] ^ next_key[63:32];
  end

  // expansion sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'd1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 4'd1;
      if (cnt_q == 4'(NumRounds)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rk_q[0] <= key_i;
      cur_q   <= key_i;
    end else if (busy_q) begin
      rk_q[cnt_q] <= next_key;
      cur_q       <= next_key;
    end
  end

  assign busy_o       = start_i | busy_q;
  assign round_keys_o = rk_q;
endmodule

>>> src/aes128_block_cipher.sv
// AES-128 ECB engine: one 128-bit block per cycle when not stalled, eleven
// pipeline stages (initial key add, then one register stage per round). A
// stall on a valid output beat freezes the whole pipeline. Writing either key
// register starts a key expansion that produces one round key per cycle; the
// input stalls after the write until the expansion ends (and likewise after
// reset, which expands the all-zero key).
// depends on aes_pkg, aes_round, aes_key_expand, aes128_block_cipher_assert.svh
`include "aes128_block_cipher_assert.svh"
module aes128_block_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aes_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aes_pkg::out_beat_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import aes_pkg::*;

  logic [63:0]               key_high_q, key_low_q;
  logic                      decrypt_q, start_q, cfg_wr, kx_busy, pipe_en;
  logic [NumKeys-1:0][127:0] rks;
  logic [127:0]              st [NumKeys];
  logic                      vld [NumKeys];
  logic [127:0]              st0_q;
  logic                      vld0_q;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      decrypt_q  <= 1'b0;
      start_q    <= 1'b1;
    end else begin
      start_q <= 1'b0;
      if (cfg_wr) begin
        case (paddr[4:3])
          REG_KEY_HIGH: begin
            key_high_q <= pwdata;
            start_q    <= 1'b1;
          end
          REG_KEY_LOW: begin
            key_low_q <= pwdata;
            start_q   <= 1'b1;
          end
          REG_DECRYPT: decrypt_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:3])
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LOW:  prdata = key_low_q;
      REG_DECRYPT:  prdata = {63'd0, decrypt_q};
      default:      prdata = '0;
    endcase
  end

  aes_key_expand u_kx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_q),
    .key_i        ({key_high_q, key_low_q}),
    .busy_o       (kx_busy),
    .round_keys_o (rks)
  );

  // pipeline advances unless the output beat is held
  assign pipe_en    = !(vld[NumRounds] && out_stall_i);
  assign in_stall_o = !pipe_en || kx_busy;

  // stage zero: initial key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (pipe_en) begin
      vld0_q <= in_valid_i && !kx_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st0_q <= {in_data_i.block_high, in_data_i.block_low}
               ^ (decrypt_q ? rks[NumRounds] : rks[0]);
    end
  end

  assign st[0]  = st0_q;
  assign vld[0] = vld0_q;

  // round stages
  for (genvar i = 1; i <= NumRounds; i++) begin : g_round
    aes_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (pipe_en),
      .decrypt_i (decrypt_q),
      .last_i    (i == NumRounds),
      .valid_i   (vld[i-1]),
      .state_i   (st[i-1]),
      .key_i     (decrypt_q ? rks[NumRounds-i] : rks[i]),
      .valid_o   (vld[i]),
      .state_o   (st[i])
    );
  end

  assign out_valid_o            = vld[NumRounds];
  assign out_data_o.result_high = st[NumRounds][127:64];
  assign out_data_o.result_low  = st[NumRounds][63:0];

  // no beat enters while round keys are being rebuilt
  `AES_ASSERT_IMPLIES(a_no_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, !kx_busy)
  // a frozen pipeline keeps its output valid bit
  `AES_ASSERT_HOLDS(a_frozen_holds, clk_i, rst_ni, !pipe_en, vld[NumRounds])
endmodule

>>> tb/tb_aes128_block_cipher.sv
// self-checking bench for the aes-128 ecb engine: random blocks, keys and direction
// depends on aes_pkg and aes128_block_cipher; expected blocks come from a local cipher model
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
  import aes_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PipeDepth  = 11;
  localparam logic [4:0] AddrKeyHigh = 5'(REG_KEY_HIGH) << 3;
  localparam logic [4:0] AddrKeyLow  = 5'(REG_KEY_LOW) << 3;
  localparam logic [4:0] AddrDecrypt = 5'(REG_DECRYPT) << 3;
  localparam logic [4:0] AddrUnused  = 5'd3 << 3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_beat_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int unsigned error_count;
  int unsigned cycle_count;
  bit          stall_chaos;

  aes128_block_cipher dut (.*);

  // prints one line per mismatch and counts it
  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // cipher model with its own key schedule and direction
  class cipher_scoreboard;
    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic         decrypt;
    logic [127:0] round_keys [11];
    logic [127:0] pending_blocks [$];

    function new();
      key_hi  = '0;
      key_lo  = '0;
      decrypt = 1'b0;
      expand();
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p ^= a;
        a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      end
      return p;
    endfunction

    function automatic void expand();
      logic [7:0] w [176];
      logic [7:0] t [4];
      logic [7:0] first;
      for (int i = 0; i < 8; i++) begin
        w[i]     = key_hi[63-8*i -: 8];
        w[8 + i] = key_lo[63-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) t[j] = w[(i-1)*4 + j];
        if (i % 4 == 0) begin
          first = t[0];
          t[0] = SBOX[t[1]] ^ RCON[i/4];
          t[1] = SBOX[t[2]];
          t[2] = SBOX[t[3]];
          t[3] = SBOX[first];
        end
        for (int j = 0; j < 4; j++) w[i*4 + j] = w[(i-4)*4 + j] ^ t[j];
      end
      for (int r = 0; r < 11; r++)
        for (int i = 0; i < 16; i++) round_keys[r][127-8*i -: 8] = w[r*16 + i];
    endfunction

    function automatic void write_reg(input logic [4:0] addr, input logic [63:0] value);
      if (addr == AddrKeyHigh) begin
        key_hi = value;
        expand();
      end else if (addr == AddrKeyLow) begin
        key_lo = value;
        expand();
      end else if (addr == AddrDecrypt) begin
        decrypt = value[0];
      end
    endfunction

    function automatic logic [127:0] cipher(input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a [4];
      int unsigned src;
      logic [127:0] res;
      bit inv;
      inv = decrypt;
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[inv ? 10 : 0][127-8*i -: 8];
      for (int step = 1; step <= 10; step++) begin
        // substitution then row rotation (order is irrelevant, both bytewise)
        for (int i = 0; i < 16; i++) t[i] = inv ? INV_SBOX[s[i]] : SBOX[s[i]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
            s[c*4 + r] = t[src*4 + r];
          end
        // inverse cipher adds the round key before the column mix
        if (inv)
          for (int i = 0; i < 16; i++) s[i] ^= round_keys[10 - step][127-8*i -: 8];
        if (step < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[c*4 + k];
            for (int r = 0; r < 4; r++) begin
              s[c*4 + r] = 0;
              for (int k = 0; k < 4; k++)
                s[c*4 + r] ^= inv ?
                  gmul(k == r ? 8'd14 : (k - r + 4) % 4 == 1 ? 8'd11 :
                       (k - r + 4) % 4 == 2 ? 8'd13 : 8'd9, a[k]) :
                  gmul(k == r ? 8'd2 : (k - r + 4) % 4 == 1 ? 8'd3 : 8'd1, a[k]);
            end
          end
        end
        // forward cipher adds the round key after the column mix
        if (!inv)
          for (int i = 0; i < 16; i++) s[i] ^= round_keys[step][127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
    endfunction

    function automatic void note_block(input in_beat_t beat);
      pending_blocks.push_back(cipher({beat.block_high, beat.block_low}));
    endfunction

    task automatic check_result(input out_beat_t beat);
      logic [127:0] want;
      if (pending_blocks.size() == 0) begin
        report_error($sformatf("unexpected result %h", beat));
        return;
      end
      want = pending_blocks.pop_front();
      if (beat.result_high !== want[127:64])
        report_error($sformatf("result_high %h, expected %h", beat.result_high, want[127:64]));
      if (beat.result_low !== want[63:0])
        report_error($sformatf("result_low %h, expected %h", beat.result_low, want[63:0]));
    endtask
  endclass

  cipher_scoreboard blocks_sb;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL aes128_block_cipher");
      $finish;
    end
  end

  // monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) blocks_sb.note_block(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) blocks_sb.check_result(out_data_o);
  end

  // receiver stall pattern: quiet stretches alternate with random stalls
  always @(posedge clk_i) begin
    if (($urandom % 64) == 0) stall_chaos <= ~stall_chaos;
    out_stall_i <= stall_chaos ? ($urandom % 3 == 0) : 1'b0;
  end

  // register write on the configuration port: setup phase, then access phase until pready
  task automatic write_reg(input logic [4:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    blocks_sb.write_reg(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // send one block, hold it until accepted
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    in_valid_i <= 1'b1;
    in_data_i  <= '{block_high: hi, block_low: lo};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // bursts of random blocks with random gaps
  task automatic send_random(input int unsigned count);
    int unsigned burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > count) burst = count;
      for (int i = 0; i < burst; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
      count -= burst;
      if ($urandom % 3 != 0) idle_input($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
  endtask

  // wait until the pipeline has drained, then a little longer
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (blocks_sb.pending_blocks.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  initial begin
    blocks_sb   = new();
    error_count = 0;
    cycle_count = 0;
    stall_chaos = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, extreme blocks, encrypt
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    drain();

    // standard test vector key, then both directions
    write_reg(AddrKeyHigh, 64'h0001020304050607);
    write_reg(AddrKeyLow, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('1, '0);
    drain();
    write_reg(AddrDecrypt, 64'h1);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block('0, '1);
    drain();

    // ignored register index, upper direction bits ignored, all-ones key
    write_reg(AddrUnused, '1);
    write_reg(AddrDecrypt, 64'hfffffffffffffffe);
    write_reg(AddrKeyHigh, '1);
    write_reg(AddrKeyLow, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_reg(AddrDecrypt, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    // random phases over keys and direction; one key half written mid-phase set
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(AddrKeyHigh, {$urandom, $urandom});
      if (phase != 3) write_reg(AddrKeyLow, {$urandom, $urandom});
      write_reg(AddrDecrypt, {$urandom, $urandom});
      send_random(74);
      drain();
    end

    if (error_count == 0) begin
      $display("PASS aes128_block_cipher");
    end else begin
      $display("FAIL aes128_block_cipher");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/aes_pkg.sv
src/aes_round.sv
src/aes_key_expand.sv
src/aes128_block_cipher.sv
tb/tb_aes128_block_cipher.sv
